// File: rtl/bmvg_pkg.sv
package bmvg_pkg;

  localparam int MAX_SEGMENTS = 255;

  localparam int EXT_W    = 16;
  localparam int SEG_W    = 8;
  localparam int POS_W    = 16;
  localparam int TEX_W    = 16;
  localparam int TEX_FRAC = 15;
  localparam int IDX_W    = 19;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int PROD_W   = 2 * (SEG_W + 1);

  // Divider: numerator, divisor and quotient widths, one quotient bit per stage
  localparam int NUM_W      = 25;
  localparam int DEN_W      = SEG_W + 1;
  localparam int QUO_W      = 16;
  localparam int DIV_STAGES = QUO_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_SETTLE  = 2;

  typedef enum logic [2:0] {
    REG_BOX_WIDTH,
    REG_BOX_HEIGHT,
    REG_BOX_DEPTH,
    REG_SEGMENTS_X,
    REG_SEGMENTS_Y,
    REG_SEGMENTS_Z
  } reg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef enum logic [2:0] {
    FACE_POS_X,
    FACE_NEG_X,
    FACE_POS_Y,
    FACE_NEG_Y,
    FACE_POS_Z,
    FACE_NEG_Z
  } face_e;

  typedef struct packed {
    logic [EXT_W-1:0]            ext_x;
    logic [EXT_W-1:0]            ext_y;
    logic [EXT_W-1:0]            ext_z;
    logic [SEG_W-1:0]            seg_x;
    logic [SEG_W-1:0]            seg_y;
    logic [SEG_W-1:0]            seg_z;
    logic [5:0][IDX_W-1:0]       base;
  } cfg_t;

  typedef struct packed {
    logic                    bad;
    axis_e                   axis_u;
    axis_e                   axis_v;
    axis_e                   axis_w;
    logic                    neg_u;
    logic                    neg_v;
    logic signed [POS_W-1:0] pos_w;
    logic signed [1:0]       nrm_w;
    logic [IDX_W-1:0]        vidx;
    logic [SEG_W-1:0]        gx;
    logic                    last_row;
    logic                    cell_valid;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [NUM_W-1:0] num_u;
    logic [NUM_W-1:0] num_v;
    logic [NUM_W-1:0] num_tu;
    logic [NUM_W-1:0] num_tv;
    logic [DEN_W-1:0] den_u;
    logic [DEN_W-1:0] den_v;
    logic [DEN_W-1:0] den_tu;
    logic [DEN_W-1:0] den_tv;
  } job_t;

endpackage

// File: rtl/box_mesh_vertex_generator_top.sv
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+---------------------------------
// command   | face_i, column_i, row_i                 | taken when start && !busy
// result    | pos_*_o, normal_*_o, tex_*_o, indices   | done_o high one cycle, no stall
// config    | psel penable pwrite paddr pwdata prdata | APB write, pready tied high
//
// One item per cycle sustained while busy stays low; each item reaches the result ports
// through the queue entry written at the accepting edge, which feeds the first of 16 radix-2
// divider stages (one quotient bit each), then one output register.
// Reset (rst_ni low, asynchronous) loads the register defaults; busy stays high after
// reset and after every register write while the face bases settle.
// The result side cannot stall, so the back end drains the queue every cycle; busy
// otherwise rises only when the queue is full.
module box_mesh_vertex_generator_top import bmvg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              face_i,
  input  logic [7:0]              column_i,
  input  logic [7:0]              row_i,
  output logic                    done_o,
  output logic signed [POS_W-1:0] pos_x_o,
  output logic signed [POS_W-1:0] pos_y_o,
  output logic signed [POS_W-1:0] pos_z_o,
  output logic signed [1:0]       normal_x_o,
  output logic signed [1:0]       normal_y_o,
  output logic signed [1:0]       normal_z_o,
  output logic [TEX_W-1:0]        tex_u_o,
  output logic [TEX_W-1:0]        tex_v_o,
  output logic [IDX_W-1:0]        vertex_index_o,
  output logic                    cell_valid_o,
  output logic [IDX_W-1:0]        index_below_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  cfg_t cfg;
  logic settling, full, push, q_valid, pop;
  job_t job_in, job_out;

  // Registers plus derived per-face vertex bases
  bmvg_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg), .settling_o(settling)
  );

  // Decode face, clamp the grid point, form numerators and the vertex index
  bmvg_front u_front (
    .start, .full_i(full), .settling_i(settling),
    .face_i, .column_i, .row_i, .cfg_i(cfg),
    .busy, .push_o(push), .job_o(job_in)
  );

  // Hold classified items between front and back
  bmvg_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(job_in), .pop_i(pop),
    .valid_o(q_valid), .full_o(full), .job_o(job_out)
  );

  // Divide, saturate, route to axes
  bmvg_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .job_i(job_out), .pop_o(pop),
    .done_o, .pos_x_o, .pos_y_o, .pos_z_o,
    .normal_x_o, .normal_y_o, .normal_z_o,
    .tex_u_o, .tex_v_o, .vertex_index_o, .cell_valid_o, .index_below_o
  );

  a_write_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite) |=> busy)
    else $error("item taken while bases settle");

  a_below_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && cell_valid_o) |-> index_below_o != '0)
    else $error("cell start without a row below");

endmodule

// File: rtl/bmvg_cfg.sv
module bmvg_cfg import bmvg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o,
  output logic              settling_o
);

  localparam int SET_W = $clog2(CFG_SETTLE + 1);

  logic [EXT_W-1:0] width_q, height_q, depth_q;
  logic [SEG_W-1:0] segx_q, segy_q, segz_q;
  logic [SET_W-1:0] settle_q;
  logic [PROD_W-1:0] p_zy_q, p_xz_q, p_xy_q;
  logic [5:0][IDX_W-1:0] base_q;
  logic [SEG_W-1:0] sx, sy, sz;
  logic [IDX_W-1:0] zy, xz, xy;
  logic wr_en;
  reg_idx_e idx;

  function automatic logic [SEG_W-1:0] eff_seg(input logic [SEG_W-1:0] s);
    if (s == '0) begin
      return SEG_W'(1);
    end else if (32'(s) > MAX_SEGMENTS) begin
      return SEG_W'(MAX_SEGMENTS);
    end
    return s;
  endfunction

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= EXT_W'(256);
      height_q <= EXT_W'(256);
      depth_q  <= EXT_W'(256);
      segx_q   <= SEG_W'(1);
      segy_q   <= SEG_W'(1);
      segz_q   <= SEG_W'(1);
      settle_q <= SET_W'(CFG_SETTLE);
    end else begin
      if (wr_en) begin
        settle_q <= SET_W'(CFG_SETTLE);
        case (idx)
          REG_BOX_WIDTH:  width_q  <= pwdata[EXT_W-1:0];
          REG_BOX_HEIGHT: height_q <= pwdata[EXT_W-1:0];
          REG_BOX_DEPTH:  depth_q  <= pwdata[EXT_W-1:0];
          REG_SEGMENTS_X: segx_q   <= pwdata[SEG_W-1:0];
          REG_SEGMENTS_Y: segy_q   <= pwdata[SEG_W-1:0];
          REG_SEGMENTS_Z: segz_q   <= pwdata[SEG_W-1:0];
          default: ;
        endcase
      end else if (settle_q != '0) begin
        settle_q <= settle_q - SET_W'(1);
      end
    end
  end

  always_comb begin
    case (idx)
      REG_BOX_WIDTH:  prdata = DATA_W'(width_q);
      REG_BOX_HEIGHT: prdata = DATA_W'(height_q);
      REG_BOX_DEPTH:  prdata = DATA_W'(depth_q);
      REG_SEGMENTS_X: prdata = DATA_W'(segx_q);
      REG_SEGMENTS_Y: prdata = DATA_W'(segy_q);
      REG_SEGMENTS_Z: prdata = DATA_W'(segz_q);
      default:        prdata = '0;
    endcase
  end

  assign sx = eff_seg(segx_q);
  assign sy = eff_seg(segy_q);
  assign sz = eff_seg(segz_q);

  // Vertex counts per face pair, then running face bases
  always_ff @(posedge clk_i) begin
    p_zy_q <= ({1'b0, sz} + DEN_W'(1)) * ({1'b0, sy} + DEN_W'(1));
    p_xz_q <= ({1'b0, sx} + DEN_W'(1)) * ({1'b0, sz} + DEN_W'(1));
    p_xy_q <= ({1'b0, sx} + DEN_W'(1)) * ({1'b0, sy} + DEN_W'(1));
  end

  assign zy = IDX_W'(p_zy_q);
  assign xz = IDX_W'(p_xz_q);
  assign xy = IDX_W'(p_xy_q);

  always_ff @(posedge clk_i) begin
    base_q[0] <= '0;
    base_q[1] <= zy;
    base_q[2] <= zy + zy;
    base_q[3] <= zy + zy + xz;
    base_q[4] <= zy + zy + xz + xz;
    base_q[5] <= zy + zy + xz + xz + xy;
  end

  assign cfg_o.ext_x = width_q;
  assign cfg_o.ext_y = height_q;
  assign cfg_o.ext_z = depth_q;
  assign cfg_o.seg_x = sx;
  assign cfg_o.seg_y = sy;
  assign cfg_o.seg_z = sz;
  assign cfg_o.base  = base_q;
  assign settling_o  = (settle_q != '0);

endmodule

// File: rtl/bmvg_front.sv
module bmvg_front import bmvg_pkg::*; (
  input  logic       start,
  input  logic       full_i,
  input  logic       settling_i,
  input  logic [2:0] face_i,
  input  logic [7:0] column_i,
  input  logic [7:0] row_i,
  input  cfg_t       cfg_i,
  output logic       busy,
  output logic       push_o,
  output job_t       job_o
);

  logic             bad, udir_neg, vdir_neg, wpos;
  axis_e            au, av, aw;
  logic [IDX_W-1:0] base_f;
  logic [EXT_W-1:0] eu, ev, ew;
  logic [SEG_W-1:0] gx, gy, ix, iy, mag_u, mag_v;
  logic [SEG_W+1:0] du, dv, adu, adv;
  logic [EXT_W+SEG_W-1:0] prod_u, prod_v;
  logic [PROD_W-1:0] rowoff;
  logic [EXT_W:0]   half_w;

  function automatic logic [EXT_W-1:0] ext_sel(input axis_e a, input cfg_t c);
    case (a)
      AXIS_X:  return c.ext_x;
      AXIS_Y:  return c.ext_y;
      AXIS_Z:  return c.ext_z;
      default: return c.ext_x;
    endcase
  endfunction

  function automatic logic [SEG_W-1:0] seg_sel(input axis_e a, input cfg_t c);
    case (a)
      AXIS_X:  return c.seg_x;
      AXIS_Y:  return c.seg_y;
      AXIS_Z:  return c.seg_z;
      default: return c.seg_x;
    endcase
  endfunction

  assign busy   = full_i | settling_i;
  assign push_o = start & ~busy;

  // Classify the face
  always_comb begin
    bad      = 1'b0;
    au       = AXIS_X;
    av       = AXIS_Y;
    aw       = AXIS_Z;
    udir_neg = 1'b0;
    vdir_neg = 1'b1;
    wpos     = 1'b0;
    base_f   = '0;
    case (face_e'(face_i))
      FACE_POS_X: begin
        au = AXIS_Z; av = AXIS_Y; aw = AXIS_X;
        udir_neg = 1'b1; wpos = 1'b1; base_f = cfg_i.base[0];
      end
      FACE_NEG_X: begin
        au = AXIS_Z; av = AXIS_Y; aw = AXIS_X;
        base_f = cfg_i.base[1];
      end
      FACE_POS_Y: begin
        au = AXIS_X; av = AXIS_Z; aw = AXIS_Y;
        vdir_neg = 1'b0; wpos = 1'b1; base_f = cfg_i.base[2];
      end
      FACE_NEG_Y: begin
        au = AXIS_X; av = AXIS_Z; aw = AXIS_Y;
        base_f = cfg_i.base[3];
      end
      FACE_POS_Z: begin
        wpos = 1'b1; base_f = cfg_i.base[4];
      end
      FACE_NEG_Z: begin
        udir_neg = 1'b1; base_f = cfg_i.base[5];
      end
      default: bad = 1'b1;
    endcase
  end

  always_comb begin
    eu = ext_sel(au, cfg_i);
    ev = ext_sel(av, cfg_i);
    ew = ext_sel(aw, cfg_i);
    gx = seg_sel(au, cfg_i);
    gy = seg_sel(av, cfg_i);
    ix = (column_i > gx) ? gx : column_i;
    iy = (row_i > gy) ? gy : row_i;

    // Offset from the face center in half segments
    du     = {1'b0, ix, 1'b0} - {2'b00, gx};
    dv     = {1'b0, iy, 1'b0} - {2'b00, gy};
    adu    = du[SEG_W+1] ? (~du + (SEG_W+2)'(1)) : du;
    adv    = dv[SEG_W+1] ? (~dv + (SEG_W+2)'(1)) : dv;
    mag_u  = adu[SEG_W-1:0];
    mag_v  = adv[SEG_W-1:0];
    prod_u = eu * mag_u;
    prod_v = ev * mag_v;
    rowoff = ({1'b0, gx} + DEN_W'(1)) * iy;
    half_w = ({1'b0, ew} + (EXT_W+1)'(1)) >> 1;

    job_o.side.bad        = bad;
    job_o.side.axis_u     = au;
    job_o.side.axis_v     = av;
    job_o.side.axis_w     = aw;
    job_o.side.neg_u      = udir_neg ^ du[SEG_W+1];
    job_o.side.neg_v      = vdir_neg ^ dv[SEG_W+1];
    if (wpos) begin
      job_o.side.pos_w = half_w[EXT_W-1] ? POS_W'(32767) : POS_W'(half_w);
    end else begin
      job_o.side.pos_w = POS_W'(~half_w + (EXT_W+1)'(1));
    end
    job_o.side.nrm_w      = (wpos && ew != '0) ? 2'sd1 : -2'sd1;
    job_o.side.vidx       = base_f + IDX_W'(ix) + IDX_W'(rowoff);
    job_o.side.gx         = gx;
    job_o.side.last_row   = (iy == gy);
    job_o.side.cell_valid = (ix < gx) && (iy < gy);

    // Round half away from zero: (|n| + g) / 2g
    job_o.num_u  = NUM_W'(prod_u) + NUM_W'(gx);
    job_o.num_v  = NUM_W'(prod_v) + NUM_W'(gy);
    job_o.den_u  = {gx, 1'b0};
    job_o.den_v  = {gy, 1'b0};
    job_o.num_tu = (NUM_W'(ix) << TEX_FRAC) + NUM_W'(gx >> 1);
    job_o.num_tv = (NUM_W'(gy - iy) << TEX_FRAC) + NUM_W'(gy >> 1);
    job_o.den_tu = DEN_W'(gx);
    job_o.den_tv = DEN_W'(gy);
  end

endmodule

// File: rtl/bmvg_queue.sv
module bmvg_queue import bmvg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic valid_o,
  output logic full_o,
  output job_t job_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign job_o   = mem_q[rd_q];
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || do_pop)
    else $error("push into full queue");

endmodule

// File: rtl/bmvg_div.sv
module bmvg_div import bmvg_pkg::*; (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  logic [NUM_W-1:0] rem_q [DIV_STAGES];
  logic [DEN_W-1:0] den_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];

  // One restoring step per stage, quotient MSB first
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [NUM_W-1:0] rem_in, trial;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign trial = NUM_W'(den_in) << (QUO_W - 1 - s);

    always_ff @(posedge clk_i) begin
      den_q[s] <= den_in;
      if (rem_in >= trial) begin
        rem_q[s] <= rem_in - trial;
        quo_q[s] <= quo_in | (QUO_W'(1) << (QUO_W - 1 - s));
      end else begin
        rem_q[s] <= rem_in;
        quo_q[s] <= quo_in;
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule

// File: rtl/bmvg_back.sv
module bmvg_back import bmvg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  job_t                    job_i,
  output logic                    pop_o,
  output logic                    done_o,
  output logic signed [POS_W-1:0] pos_x_o,
  output logic signed [POS_W-1:0] pos_y_o,
  output logic signed [POS_W-1:0] pos_z_o,
  output logic signed [1:0]       normal_x_o,
  output logic signed [1:0]       normal_y_o,
  output logic signed [1:0]       normal_z_o,
  output logic [TEX_W-1:0]        tex_u_o,
  output logic [TEX_W-1:0]        tex_v_o,
  output logic [IDX_W-1:0]        vertex_index_o,
  output logic                    cell_valid_o,
  output logic [IDX_W-1:0]        index_below_o
);

  logic        valid_q [DIV_STAGES];
  side_t       side_q  [DIV_STAGES];
  logic [QUO_W-1:0] q_u, q_v, q_tu, q_tv;
  logic signed [POS_W-1:0] pu, pv;
  side_t       sd;
  logic        done_q;

  function automatic logic signed [POS_W-1:0] coord(input logic [QUO_W-1:0] q,
                                                    input logic neg);
    if (neg) begin
      return POS_W'(~q + QUO_W'(1));
    end else if (q[QUO_W-1]) begin
      return POS_W'(32767);
    end
    return POS_W'(q);
  endfunction

  function automatic logic signed [POS_W-1:0] pick(input axis_e a, input side_t s,
                                                   input logic signed [POS_W-1:0] u,
                                                   input logic signed [POS_W-1:0] v);
    if (s.axis_u == a) begin
      return u;
    end else if (s.axis_v == a) begin
      return v;
    end
    return s.pos_w;
  endfunction

  // Take an item whenever the queue has one: this side never stalls
  assign pop_o = valid_i;

  bmvg_div u_div_u  (.clk_i, .num_i(job_i.num_u),  .den_i(job_i.den_u),  .quo_o(q_u));
  bmvg_div u_div_v  (.clk_i, .num_i(job_i.num_v),  .den_i(job_i.den_v),  .quo_o(q_v));
  bmvg_div u_div_tu (.clk_i, .num_i(job_i.num_tu), .den_i(job_i.den_tu), .quo_o(q_tu));
  bmvg_div u_div_tv (.clk_i, .num_i(job_i.num_tv), .den_i(job_i.den_tv), .quo_o(q_tv));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        valid_q[s] <= 1'b0;
      end
      done_q <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
      for (int s = 1; s < DIV_STAGES; s++) begin
        valid_q[s] <= valid_q[s-1];
      end
      done_q <= valid_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= job_i.side;
    for (int s = 1; s < DIV_STAGES; s++) begin
      side_q[s] <= side_q[s-1];
    end
  end

  assign sd = side_q[DIV_STAGES-1];
  assign pu = coord(q_u, sd.neg_u);
  assign pv = coord(q_v, sd.neg_v);

  // Route to axes and drop everything for an unknown face
  always_ff @(posedge clk_i) begin
    if (sd.bad) begin
      pos_x_o        <= '0;
      pos_y_o        <= '0;
      pos_z_o        <= '0;
      normal_x_o     <= '0;
      normal_y_o     <= '0;
      normal_z_o     <= '0;
      tex_u_o        <= '0;
      tex_v_o        <= '0;
      vertex_index_o <= '0;
      cell_valid_o   <= 1'b0;
      index_below_o  <= '0;
    end else begin
      pos_x_o        <= pick(AXIS_X, sd, pu, pv);
      pos_y_o        <= pick(AXIS_Y, sd, pu, pv);
      pos_z_o        <= pick(AXIS_Z, sd, pu, pv);
      normal_x_o     <= (sd.axis_w == AXIS_X) ? sd.nrm_w : 2'sd0;
      normal_y_o     <= (sd.axis_w == AXIS_Y) ? sd.nrm_w : 2'sd0;
      normal_z_o     <= (sd.axis_w == AXIS_Z) ? sd.nrm_w : 2'sd0;
      tex_u_o        <= q_tu;
      tex_v_o        <= q_tv;
      vertex_index_o <= sd.vidx;
      cell_valid_o   <= sd.cell_valid;
      index_below_o  <= sd.last_row ? '0 : sd.vidx + IDX_W'(sd.gx) + IDX_W'(1);
    end
  end

  assign done_o = done_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(valid_i, DIV_STAGES + 1))
    else $error("result strobe out of step with popped item");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bmvg_pkg::*;

  // Expected vertex record, one per accepted item
  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic signed [1:0]       nx;
    logic signed [1:0]       ny;
    logic signed [1:0]       nz;
    logic [TEX_W-1:0]        tu;
    logic [TEX_W-1:0]        tv;
    logic [IDX_W-1:0]        vidx;
    logic                    cv;
    logic [IDX_W-1:0]        below;
  } vertex_t;

  // Directed stimulus row; has_exp marks rows with a typed-in vertex
  typedef struct {
    logic [2:0] face;
    logic [7:0] col;
    logic [7:0] row;
    bit         has_exp;
    vertex_t    vtx;
  } grid_row_t;

  localparam int LATENCY     = 17;
  localparam int CYCLE_LIMIT = 400000;

  logic                    clk_i, rst_ni;
  logic                    start;
  logic                    busy;
  logic [2:0]              face_i;
  logic [7:0]              column_i, row_i;
  logic                    done_o;
  logic signed [POS_W-1:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [1:0]       normal_x_o, normal_y_o, normal_z_o;
  logic [TEX_W-1:0]        tex_u_o, tex_v_o;
  logic [IDX_W-1:0]        vertex_index_o, index_below_o;
  logic                    cell_valid_o;
  logic                    psel, penable, pwrite;
  logic [ADDR_W-1:0]       paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  // Shadow copy of the box setup
  int unsigned ext_q[3];
  int unsigned seg_q[3];

  vertex_t vertex_fifo[$];
  int      mismatches;
  int      cycle_cnt;
  int      gap_pct;

  box_mesh_vertex_generator_top i_dut (.*);

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // Global watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("box_mesh_vertex_generator_top regression: fail");
      $finish;
    end
  end

  function automatic longint round_away(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint eff_segments(int unsigned s);
    longint v;
    v = (s == 0) ? 1 : s;
    if (v > MAX_SEGMENTS) v = MAX_SEGMENTS;
    return v;
  endfunction

  // Compute the vertex that a grid point request produces
  function automatic vertex_t mesh_vertex(logic [2:0] f, logic [7:0] c, logic [7:0] r);
    int      ua[6] = '{2, 2, 0, 0, 0, 0};
    int      va[6] = '{1, 1, 2, 2, 1, 1};
    int      wa[6] = '{0, 0, 1, 1, 2, 2};
    int      ud[6] = '{-1, 1, 1, 1, 1, -1};
    int      vd[6] = '{-1, -1, 1, -1, -1, -1};
    int      ws[6] = '{1, -1, 1, -1, 1, -1};
    longint  sg[3], ps[3], nm[3];
    longint  gx, gy, ix, iy, base, idx, ew, eu, ev;
    vertex_t v;
    v = '0;
    if (f > 5) return v;
    for (int a = 0; a < 3; a++) sg[a] = eff_segments(seg_q[a]);
    gx = sg[ua[f]];
    gy = sg[va[f]];
    ix = (c > gx) ? gx : c;
    iy = (r > gy) ? gy : r;
    eu = ext_q[ua[f]];
    ev = ext_q[va[f]];
    ps[ua[f]] = clip16(ud[f] * round_away(2 * ix * eu - gx * eu, 2 * gx));
    ps[va[f]] = clip16(vd[f] * round_away(2 * iy * ev - gy * ev, 2 * gy));
    ew = ws[f] * longint'(ext_q[wa[f]]);
    ps[wa[f]] = clip16(round_away(ew, 2));
    nm = '{0, 0, 0};
    nm[wa[f]] = (ew > 0) ? 1 : -1;
    base = 0;
    for (int k = 0; k < f; k++) base += (sg[ua[k]] + 1) * (sg[va[k]] + 1);
    idx = base + ix + (gx + 1) * iy;
    v.px = POS_W'(ps[0]); v.py = POS_W'(ps[1]); v.pz = POS_W'(ps[2]);
    v.nx = 2'(nm[0]); v.ny = 2'(nm[1]); v.nz = 2'(nm[2]);
    v.tu = TEX_W'((ix * 32768 + gx / 2) / gx);
    v.tv = TEX_W'(((gy - iy) * 32768 + gy / 2) / gy);
    v.vidx = IDX_W'(idx);
    v.cv = (ix < gx) && (iy < gy);
    v.below = IDX_W'((iy < gy) ? idx + gx + 1 : 0);
    return v;
  endfunction

  // Compare each done strobe with the oldest pending vertex
  always @(posedge clk_i) begin
    vertex_t got, want;
    if (rst_ni && done_o) begin
      got = '{pos_x_o, pos_y_o, pos_z_o, normal_x_o, normal_y_o, normal_z_o,
              tex_u_o, tex_v_o, vertex_index_o, cell_valid_o, index_below_o};
      if (vertex_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex %h", got);
      end else begin
        want = vertex_fifo.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("vertex mismatch: exp %h got %h", want, got);
        end
      end
    end
  end

  // Write one register over APB; the block is idle here
  task automatic reg_write(reg_idx_e ri, logic [DATA_W-1:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'(4 * int'(ri)); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (ri)
      REG_BOX_WIDTH:  ext_q[0] = val[15:0];
      REG_BOX_HEIGHT: ext_q[1] = val[15:0];
      REG_BOX_DEPTH:  ext_q[2] = val[15:0];
      REG_SEGMENTS_X: seg_q[0] = val[7:0];
      REG_SEGMENTS_Y: seg_q[1] = val[7:0];
      default:        seg_q[2] = val[7:0];
    endcase
  endtask

  task automatic box_setup(int unsigned w, int unsigned h, int unsigned d,
                           int unsigned sx, int unsigned sy, int unsigned sz);
    reg_write(REG_BOX_WIDTH, w);
    reg_write(REG_BOX_HEIGHT, h);
    reg_write(REG_BOX_DEPTH, d);
    reg_write(REG_SEGMENTS_X, sx);
    reg_write(REG_SEGMENTS_Y, sy);
    reg_write(REG_SEGMENTS_Z, sz);
  endtask

  // Hold start until the item is taken; insert sender gaps by gap_pct
  task automatic send_point(logic [2:0] f, logic [7:0] c, logic [7:0] r,
                            bit has_exp, vertex_t vx);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1; face_i <= f; column_i <= c; row_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    vertex_fifo.push_back(has_exp ? vx : mesh_vertex(f, c, r));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (vertex_fifo.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Pick a segment count, mostly small, sometimes zero or the maximum
  function automatic int unsigned pick_seg();
    int unsigned k;
    k = $urandom_range(9);
    if (k == 0) return 0;
    if (k == 1) return 255;
    return $urandom_range(1, 12);
  endfunction

  function automatic logic [7:0] pick_coord(int unsigned s);
    int unsigned g;
    g = (s == 0) ? 1 : s;
    if ($urandom_range(9) == 0) return 8'($urandom);
    return 8'($urandom_range(g));
  endfunction

  initial begin
    grid_row_t dir_rows[$];
    vertex_t   vx;
    int        ua[6] = '{2, 2, 0, 0, 0, 0};
    int        va[6] = '{1, 1, 2, 2, 1, 1};
    logic [2:0] f;

    cycle_cnt = 0; mismatches = 0; gap_pct = 0;
    rst_ni = 1'b0; start = 1'b0; face_i = '0; column_i = '0; row_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    ext_q = '{256, 256, 256};
    seg_q = '{1, 1, 1};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset corner of +z: (-0.5, +0.5, +0.5), normal +z, index 16
    vx = '{-16'sd128, 16'sd128, 16'sd128, 2'sd0, 2'sd0, 2'sd1,
           16'd0, 16'd32768, 19'd16, 1'b1, 19'd18};
    dir_rows.push_back('{3'(FACE_POS_Z), 8'd0, 8'd0, 1'b1, vx});
    // Bad faces give all-zero vertices
    dir_rows.push_back('{3'd6, 8'hff, 8'hff, 1'b1, vertex_t'('0)});
    dir_rows.push_back('{3'd7, 8'd0, 8'd0, 1'b1, vertex_t'('0)});
    for (int i = 0; i < 6; i++) begin
      dir_rows.push_back('{3'(i), 8'd0, 8'd0, 1'b0, vertex_t'('0)});
      dir_rows.push_back('{3'(i), 8'd255, 8'd255, 1'b0, vertex_t'('0)});
      dir_rows.push_back('{3'(i), 8'd1, 8'd0, 1'b0, vertex_t'('0)});
    end
    gap_pct = 9;
    foreach (dir_rows[i])
      send_point(dir_rows[i].face, dir_rows[i].col, dir_rows[i].row,
                 dir_rows[i].has_exp, dir_rows[i].vtx);
    drain();

    // Extremes: zero extents with zero segments, full extents with max segments
    box_setup(0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 6; i++) send_point(3'(i), 8'd1, 8'd1, 1'b0, vertex_t'('0));
    drain();
    box_setup(16'hffff, 16'hffff, 16'hffff, 255, 255, 255);
    for (int i = 0; i < 6; i++) send_point(3'(i), 8'd255, 8'd7, 1'b0, vertex_t'('0));
    drain();

    // Random phases: mostly in-range grid points on a fresh box
    for (int ph = 0; ph < 30; ph++) begin
      if (ph == 10) gap_pct = 82;
      if (ph == 20) gap_pct = 0;
      box_setup($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                pick_seg(), pick_seg(), pick_seg());
      repeat (60) begin
        f = ($urandom_range(19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
        send_point(f, pick_coord(seg_q[ua[f % 6]]), pick_coord(seg_q[va[f % 6]]),
                   1'b0, vertex_t'('0));
      end
      drain();
    end

    if (mismatches == 0 && vertex_fifo.size() == 0) begin
      $display("box_mesh_vertex_generator_top regression: pass");
    end else begin
      $display("box_mesh_vertex_generator_top regression: fail");
    end
    $finish;
  end

endmodule
